### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CHK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

### hdl/md2_pkg.sv
// ----------------------------------------------------------------------------
// md2_pkg
// Types, constants and the S-box shared by the MD2 engine.
// ----------------------------------------------------------------------------
package md2_pkg;

  localparam int unsigned BlockBytes  = 16;
  localparam int unsigned MixBytes    = 48;
  localparam int unsigned MixRounds   = 18;
  localparam int unsigned DigestBytes = 16;
  localparam int unsigned QueueDepth  = 4;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] digest;
    logic       last;
  } emit_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_SUM  = 5'b00100,
    S_MIX  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  // which block the engine is working on
  typedef enum logic [1:0] {
    PH_DATA  = 2'd0,
    PH_PAD   = 2'd1,
    PH_FINAL = 2'd2
  } phase_e;

  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

### hdl/md2_front.sv
// ----------------------------------------------------------------------------
// md2_front
// Input queue: takes items from the push side and hands them, classified,
// to the compression engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md2_front #(
  parameter int unsigned Depth = md2_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic            cmd_i,
  input  logic [7:0]      data_byte_i,
  output logic            valid_o,
  output md2_pkg::item_t  item_o,
  input  logic            take_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  md2_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push_ok, take_ok;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full    = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign push_ok = push && !full;
  assign take_ok = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= '{finish: cmd_i, data: data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) wr_q <= next_ptr(wr_q);
      if (take_ok) rd_q <= next_ptr(rd_q);
      if (push_ok && !take_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (take_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_take_when_empty, clk_i, rst_ni, take_i && !valid_o)
  `ASSERT_CHK(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))

endmodule

### hdl/md2_back.sv
// ----------------------------------------------------------------------------
// md2_back
// Compression engine: block buffer, checksum and 48-byte mix state as
// rotating byte lines, one S-box lookup per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md2_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  md2_pkg::item_t  item_i,
  output logic            take_o,
  output logic            emit_valid_o,
  output md2_pkg::emit_t  emit_o,
  input  logic            emit_ready_i
);

  localparam int unsigned Bb = md2_pkg::BlockBytes;
  localparam int unsigned Mb = md2_pkg::MixBytes;

  md2_pkg::state_e state_q, state_d;
  md2_pkg::phase_e phase_q, phase_d;

  logic [7:0] buf_q [Bb];
  logic [7:0] buf_d [Bb];
  logic [7:0] cs_q  [Bb];
  logic [7:0] cs_d  [Bb];
  logic [7:0] mix_q [Mb];
  logic [7:0] mix_d [Mb];

  logic [3:0] fill_q, fill_d;
  logic [3:0] step_q, step_d;
  logic [5:0] col_q, col_d;
  logic [4:0] round_q, round_d;
  logic [7:0] run_q, run_d;
  logic [4:0] pad_q, pad_d;

  logic [7:0] in_byte;
  logic       shift_in;
  logic [7:0] cs_new, mix_new;

  assign take_o       = (state_q == md2_pkg::S_IDLE) && valid_i;
  assign emit_valid_o = (state_q == md2_pkg::S_EMIT);
  assign emit_o       = '{digest: mix_q[0],
                          last: (step_q == 4'(md2_pkg::DigestBytes - 1))};

  // checksum runs off the previously written checksum byte, which sits at the tail
  assign cs_new  = cs_q[0] ^ md2_pkg::SBOX[buf_q[0] ^ cs_q[Bb-1]];
  assign mix_new = mix_q[0] ^ md2_pkg::SBOX[run_q];

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    buf_d   = buf_q;
    cs_d    = cs_q;
    mix_d   = mix_q;
    fill_d  = fill_q;
    step_d  = step_q;
    col_d   = col_q;
    round_d = round_q;
    run_d   = run_q;
    pad_d   = pad_q;
    shift_in = 1'b0;
    in_byte  = {3'b000, pad_q};

    case (state_q)
      md2_pkg::S_IDLE: begin
        if (valid_i) begin
          if (!item_i.finish) begin
            shift_in = 1'b1;
            in_byte  = item_i.data;
          end else begin
            pad_d   = 5'(Bb) - {1'b0, fill_q};
            phase_d = md2_pkg::PH_PAD;
            state_d = md2_pkg::S_PAD;
          end
        end
      end
      md2_pkg::S_PAD: begin
        shift_in = 1'b1;
      end
      md2_pkg::S_SUM: begin
        for (int k = 0; k < Bb - 1; k++) begin
          buf_d[k]      = buf_q[k+1];
          cs_d[k]       = cs_q[k+1];
          mix_d[k]      = mix_q[k+1];
          mix_d[Bb+k]   = mix_q[Bb+k+1];
          mix_d[2*Bb+k] = mix_q[2*Bb+k+1];
        end
        buf_d[Bb-1]   = buf_q[0];
        cs_d[Bb-1]    = cs_new;
        mix_d[Bb-1]   = mix_q[0];
        mix_d[2*Bb-1] = buf_q[0];
        mix_d[Mb-1]   = buf_q[0] ^ mix_q[0];
        step_d = step_q + 1'b1;
        if (step_q == 4'(Bb - 1)) begin
          col_d   = '0;
          round_d = '0;
          run_d   = '0;
          state_d = md2_pkg::S_MIX;
        end
      end
      md2_pkg::S_MIX: begin
        for (int k = 0; k < Mb - 1; k++) begin
          mix_d[k] = mix_q[k+1];
        end
        mix_d[Mb-1] = mix_new;
        run_d = mix_new;
        col_d = col_q + 1'b1;
        if (col_q == 6'(Mb - 1)) begin
          col_d   = '0;
          run_d   = mix_new + {3'b000, round_q};
          round_d = round_q + 1'b1;
          if (round_q == 5'(md2_pkg::MixRounds - 1)) begin
            step_d = '0;
            case (phase_q)
              md2_pkg::PH_PAD: begin
                // checksum goes in as the final block
                buf_d   = cs_q;
                phase_d = md2_pkg::PH_FINAL;
                state_d = md2_pkg::S_SUM;
              end
              md2_pkg::PH_FINAL: begin
                state_d = md2_pkg::S_EMIT;
              end
              default: begin
                state_d = md2_pkg::S_IDLE;
              end
            endcase
          end
        end
      end
      md2_pkg::S_EMIT: begin
        if (emit_ready_i) begin
          for (int k = 0; k < Bb - 1; k++) begin
            mix_d[k] = mix_q[k+1];
          end
          step_d = step_q + 1'b1;
          if (step_q == 4'(md2_pkg::DigestBytes - 1)) begin
            for (int k = 0; k < Bb; k++) cs_d[k] = '0;
            for (int k = 0; k < Mb; k++) mix_d[k] = '0;
            fill_d  = '0;
            step_d  = '0;
            phase_d = md2_pkg::PH_DATA;
            state_d = md2_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = md2_pkg::S_IDLE;
      end
    endcase

    // byte into the block buffer; a full buffer starts compression
    if (shift_in) begin
      for (int k = 0; k < Bb - 1; k++) begin
        buf_d[k] = buf_q[k+1];
      end
      buf_d[Bb-1] = in_byte;
      if (fill_q == 4'(Bb - 1)) begin
        fill_d  = '0;
        step_d  = '0;
        state_d = md2_pkg::S_SUM;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md2_pkg::S_IDLE;
      phase_q <= md2_pkg::PH_DATA;
      fill_q  <= '0;
      step_q  <= '0;
      col_q   <= '0;
      round_q <= '0;
      run_q   <= '0;
      pad_q   <= '0;
      for (int k = 0; k < Bb; k++) cs_q[k] <= '0;
      for (int k = 0; k < Mb; k++) mix_q[k] <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
      step_q  <= step_d;
      col_q   <= col_d;
      round_q <= round_d;
      run_q   <= run_d;
      pad_q   <= pad_d;
      cs_q    <= cs_d;
      mix_q   <= mix_d;
    end
  end

  `ASSERT_CHK(a_fill_clear_in_compress, clk_i, rst_ni,
    (state_q == md2_pkg::S_SUM || state_q == md2_pkg::S_MIX) |-> fill_q == '0)
  `ASSERT_CHK(a_emit_only_final, clk_i, rst_ni,
    (state_q == md2_pkg::S_EMIT) |-> (phase_q == md2_pkg::PH_FINAL))
  `ASSERT_CHK(a_idle_after_last, clk_i, rst_ni,
    (emit_valid_o && emit_ready_i && emit_o.last) |=> (state_q == md2_pkg::S_IDLE))

endmodule

### hdl/md2_hash.sv
// ----------------------------------------------------------------------------
// md2_hash
// MD2 message digest engine: input queue, compression engine and an
// output register for the digest bytes.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        cmd_i, data_byte_i
//  result    empty / pop        digest_byte_o, last_of_digest_o
//
//  An absorb item is shifted into the block buffer; the sixteenth byte of a block
//  starts a checksum pass and the mix rounds (one S-box lookup per cycle in
//  the serial mix loop).
//  A finish item takes up to 16 pad bytes plus two block compressions, then
//  16 digest bytes at one per cycle while pop is held.
//  Reset clears checksum and mix state at once; no item is needed to start.
//  Items queue in front while the engine is busy or results wait.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md2_hash #(
  parameter int unsigned QueueDepth = md2_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] digest_byte_o,
  output logic       last_of_digest_o
);

  logic           item_valid, item_take;
  md2_pkg::item_t item;
  logic           emit_valid, emit_ready;
  md2_pkg::emit_t emit;
  logic           out_valid_q;
  md2_pkg::emit_t out_q;

  md2_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .valid_o     (item_valid),
    .item_o      (item),
    .take_i      (item_take)
  );

  md2_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (item_valid),
    .item_i       (item),
    .take_o       (item_take),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  assign emit_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit_valid;
    end
  end

  assign empty            = !out_valid_q;
  assign digest_byte_o    = out_q.digest;
  assign last_of_digest_o = out_q.last;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for md2_hash: random messages of mixed lengths and
// finish items go in through the push/full side, and each digest byte that
// is popped is compared with a bit-true MD2 digest model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned TargetItems   = 420;
  localparam int unsigned CalmItems     = 360;  // no idling from here on
  localparam int unsigned HoldItems     = 150;  // long pop hold-off starts here
  localparam int unsigned HoldCycles    = 6000;
  localparam int unsigned DrainCycles   = 2000;
  localparam int unsigned WatchdogLimit = 30000;

  // MD2 digest model and store of expected digest bytes
  class md2_scoreboard;
    logic [7:0]     blk [md2_pkg::BlockBytes];
    int unsigned    fill;
    logic [7:0]     mix [md2_pkg::MixBytes];
    logic [7:0]     csum [md2_pkg::BlockBytes];
    md2_pkg::emit_t pending_digest [$];
    int unsigned    errors;
    int unsigned    bytes_seen;
    int unsigned    digests_seen;

    function void clear_state();
      for (int i = 0; i < md2_pkg::BlockBytes; i++) begin
        blk[i]  = '0;
        csum[i] = '0;
      end
      for (int i = 0; i < md2_pkg::MixBytes; i++) mix[i] = '0;
      fill = 0;
    endfunction

    function void compress();
      logic [7:0] run;
      run = csum[md2_pkg::BlockBytes-1];
      for (int i = 0; i < md2_pkg::BlockBytes; i++) begin
        mix[16+i] = blk[i];
        mix[32+i] = blk[i] ^ mix[i];
        csum[i]   = csum[i] ^ md2_pkg::SBOX[blk[i] ^ run];
        run       = csum[i];
      end
      run = '0;
      for (int r = 0; r < md2_pkg::MixRounds; r++) begin
        for (int j = 0; j < md2_pkg::MixBytes; j++) begin
          mix[j] = mix[j] ^ md2_pkg::SBOX[run];
          run    = mix[j];
        end
        run = run + 8'(r);
      end
    endfunction

    function void absorb(logic [7:0] b);
      blk[fill] = b;
      fill++;
      if (fill >= md2_pkg::BlockBytes) begin
        fill = 0;
        compress();
      end
    endfunction

    function void note_item(logic finish, logic [7:0] data);
      logic [7:0]     padlen;
      logic [7:0]     sum_copy [md2_pkg::BlockBytes];
      md2_pkg::emit_t e;
      if (!finish) begin
        absorb(data);
        return;
      end
      padlen = 8'(md2_pkg::BlockBytes - fill);
      for (int i = 0; i < padlen; i++) absorb(padlen);
      sum_copy = csum;
      for (int i = 0; i < md2_pkg::BlockBytes; i++) absorb(sum_copy[i]);
      for (int i = 0; i < md2_pkg::DigestBytes; i++) begin
        e.digest = mix[i];
        e.last   = (i == md2_pkg::DigestBytes - 1);
        pending_digest.push_back(e);
      end
      clear_state();
    endfunction

    function void check_result(logic [7:0] digest, logic last);
      md2_pkg::emit_t e;
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest byte %02h last %0b", $time, digest, last);
        errors++;
        return;
      end
      e = pending_digest.pop_front();
      if (digest !== e.digest) begin
        $display("%0t: digest byte expected %02h actual %02h", $time, e.digest, digest);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last flag expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
      bytes_seen++;
      if (e.last) digests_seen++;
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       cmd_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] digest_byte_o;
  logic       last_of_digest_o;

  md2_scoreboard sb;
  int unsigned   n_in = 0;
  int unsigned   n_sent = 0;
  int unsigned   quiet_cycles = 0;
  bit            calm = 1'b0;
  bit            held = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   pop_idle = 0;

  md2_hash dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .data_byte_i     (data_byte_i),
    .empty           (empty),
    .pop             (pop),
    .digest_byte_o   (digest_byte_o),
    .last_of_digest_o(last_of_digest_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Called just after a rising edge; returns just after the edge that took it.
  task automatic send_item(input logic finish, input logic [7:0] data);
    push        <= 1'b1;
    cmd_i       <= finish;
    data_byte_i <= data;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  task automatic maybe_idle();
    int unsigned gap;
    if (calm || $urandom_range(0, 5) != 0) return;
    gap = $urandom_range(1, 11);
    push <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(1'b0, 8'($urandom_range(0, 255)));
      maybe_idle();
    end
    send_item(1'b1, 8'($urandom_range(0, 255)));
    maybe_idle();
  endtask

  // accept monitor and watchdog
  always @(posedge clk_i) begin : monitor
    bit took;
    took = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_item(cmd_i, data_byte_i);
        n_in++;
        took = 1'b1;
      end
      if (pop && !empty) begin
        sb.check_result(digest_byte_o, last_of_digest_o);
        took = 1'b1;
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog: no item moved for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random pop bursts plus one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (!held && n_in >= HoldItems) begin
      held      = 1'b1;
      hold_left = HoldCycles;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (pop_idle > 0) begin
      pop_idle--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop_idle = $urandom_range(1, 11) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    int unsigned len;
    sb = new();
    sb.clear_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, with a nonzero byte on the finish item that must be ignored
    send_item(1'b1, 8'hA5);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h5A);
    // exactly one block, so finish pads with a full block of 16s
    for (int i = 0; i < md2_pkg::BlockBytes; i++) send_item(1'b0, 8'(i * 17));
    send_item(1'b1, 8'hFF);

    while (n_sent < TargetItems) begin
      if (n_sent >= CalmItems) calm = 1'b1;
      case ($urandom_range(0, 5))
        0:       len = $urandom_range(0, 3);
        1:       len = 15;
        2:       len = 16;
        3:       len = $urandom_range(17, 33);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len);
    end
    push <= 1'b0;

    while (sb.pending_digest.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d items, %0d digests (%0d bytes), with a %0d-cycle pop hold-off.",
             n_in, sb.digests_seen, sb.bytes_seen, HoldCycles);
    if (sb.errors == 0 && sb.pending_digest.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
